@@ rtl/core/bce_pkg.sv @@
// ---------------------------------------------------------------------------
// Binary cross-entropy package
// Shared constants, types, controller codes and the log2 table builder.
// ---------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

  // Item counter width and log table size.
  localparam int COUNT_BITS  = 20;
  localparam int LOG_BITS    = 10;
  localparam int LOG_ENTRIES = 1 << LOG_BITS;

  // Field widths.
  localparam int P_BITS     = 16;
  localparam int U_BITS     = 32;
  localparam int LOSS_BITS  = 21;
  localparam int GRAD_BITS  = 40;
  localparam int SUM_BITS   = 40;
  localparam int L2_BITS    = 20;
  localparam int NLN_BITS   = 20;
  localparam int PROD_BITS  = 64;
  localparam int DVD_BITS   = 64;
  localparam int DSR_BITS   = COUNT_BITS + 16;
  localparam int MUL_BITS   = 32;

  // Constants of the arithmetic.
  localparam logic [29:0]    LN2_Q30   = 30'd744261118;
  localparam logic [15:0]    ONE_Q15   = 16'd32768;
  localparam logic [14:0]    P_MAX     = 15'd32767;
  localparam logic [14:0]    P_MIN     = 15'd1;

  // Configuration register map.
  localparam int             ADDR_BITS         = 3;
  localparam logic [ADDR_BITS-1:0] REG_GRAD_ENABLE = 3'd0;

  // Result kinds.
  localparam logic KIND_FORWARD  = 1'b0;
  localparam logic KIND_BACKWARD = 1'b1;

  // Controller states.
  typedef enum logic [4:0] {
    ST_IDLE, ST_DECIDE,
    ST_LOG_A, ST_LN_A, ST_SAVE_A, ST_LOG_B, ST_LN_B, ST_SAVE_B,
    ST_MUL_YA, ST_MUL_YB, ST_ACCUM,
    ST_DIV_MEAN, ST_WAIT_MEAN, ST_OUT_LOSS,
    ST_DIV_QA, ST_WAIT_QA, ST_SAVE_QA,
    ST_DIV_QB, ST_WAIT_QB, ST_SAVE_QB,
    ST_MUL_G, ST_DIV_G, ST_WAIT_G, ST_OUT_GRAD
  } state_t;

  // Datapath commands.
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_LOG_A, OP_LOG_B, OP_LN_MUL, OP_SAVE_A, OP_SAVE_B,
    OP_MUL_YA, OP_MUL_YB, OP_ACCUM, OP_DIV_MEAN, OP_OUT_LOSS,
    OP_DIV_QA, OP_SAVE_QA, OP_DIV_QB, OP_SAVE_QB, OP_MUL_G, OP_DIV_G,
    OP_OUT_GRAD
  } op_t;

  // Status from the datapath side to the controller.
  typedef struct packed {
    logic kind;
    logic last;
    logic grad_enable;
    logic div_done;
    logic out_free;
  } status_t;

  typedef logic [L2_BITS-1:0] log_rom_t [LOG_ENTRIES];

  // log2(1 + idx/LOG_ENTRIES) in Q20 by repeated squaring.
  function automatic logic [L2_BITS-1:0] log2_entry(input int idx);
    logic [63:0]        v;
    logic [L2_BITS-1:0] r;
    v = (64'd1 << 30) + (64'(idx) << (30 - LOG_BITS));
    r = '0;
    for (int k = 0; k < L2_BITS; k++) begin
      v = (v * v) >> 30;
      r = {r[L2_BITS-2:0], 1'b0};
      if (v >= (64'd2 << 30)) begin
        v    = v >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t t;
    for (int i = 0; i < LOG_ENTRIES; i++) begin
      t[i] = log2_entry(i);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/binary_cross_entropy_unit.sv @@
// ---------------------------------------------------------------------------
// Binary cross-entropy unit
// Forward mean loss and backward gradient over Q1.15 prediction pairs.
// ---------------------------------------------------------------------------
// Forward word: log, multiply and accumulate steps run one after another;
//   the last word of a tensor adds a mean divide on the shared serial
//   divider before the loss result is registered.
// Backward word: three passes of the shared serial divider give the
//   gradient and one word is in work at a time. With gradients off a
//   backward word gives no result. A stalled result delays the next accept.
// Reset clears the loss sum and count, sets the held count to one and
//   enables gradients.
`default_nettype none

module binary_cross_entropy_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bce_pkg::ADDR_BITS-1:0]     paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              pass_kind,
  input  wire logic [bce_pkg::P_BITS-1:0]        prediction,
  input  wire logic [bce_pkg::P_BITS-1:0]        target_value,
  input  wire logic signed [bce_pkg::U_BITS-1:0] upstream_grad,
  input  wire logic                              last_item,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   result_kind,
  output logic      [bce_pkg::LOSS_BITS-1:0]     loss_mean,
  output logic signed [bce_pkg::GRAD_BITS-1:0]   grad_value,
  output logic                                   saturated,
  output logic                                   last_result
);
  import bce_pkg::*;

  logic                 grad_enable;
  op_t                  op;
  status_t              sts;
  logic [LOG_BITS-1:0]  rom_addr;
  logic [L2_BITS-1:0]   rom_q;
  logic                 div_start;
  logic [DVD_BITS-1:0]  div_dividend;
  logic [DSR_BITS-1:0]  div_divisor;
  logic [DVD_BITS-1:0]  div_quotient;
  logic                 div_done;
  logic                 item_kind;
  logic                 item_last;
  logic                 out_free;

  // Configuration register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      grad_enable <= 1'b1;
    end else if (psel && penable && pwrite && paddr == REG_GRAD_ENABLE) begin
      grad_enable <= pwdata[0];
    end
  end
  assign prdata = (paddr == REG_GRAD_ENABLE) ? {31'd0, grad_enable} : '0;

  assign sts = '{kind: item_kind, last: item_last, grad_enable: grad_enable,
                 div_done: div_done, out_free: out_free};

  bce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .op       (op)
  );

  bce_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .pass_kind     (pass_kind),
    .prediction    (prediction),
    .target_value  (target_value),
    .upstream_grad (upstream_grad),
    .last_item     (last_item),
    .rom_addr      (rom_addr),
    .rom_q         (rom_q),
    .div_start     (div_start),
    .div_dividend  (div_dividend),
    .div_divisor   (div_divisor),
    .div_quotient  (div_quotient),
    .item_kind     (item_kind),
    .item_last     (item_last),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .loss_mean     (loss_mean),
    .grad_value    (grad_value),
    .saturated     (saturated),
    .last_result   (last_result)
  );

  bce_log_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  bce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

endmodule

`default_nettype wire

@@ rtl/core/bce_log_rom.sv @@
// ---------------------------------------------------------------------------
// Log2 table
// Synchronous ROM of log2 of the mantissa fraction, Q20.
// ---------------------------------------------------------------------------
`default_nettype none

module bce_log_rom (
  input  wire logic                          clk,
  input  wire logic [bce_pkg::LOG_BITS-1:0]  addr,
  output logic      [bce_pkg::L2_BITS-1:0]   q
);
  import bce_pkg::*;

  localparam log_rom_t LOG_ROM = build_log_rom();

  // Registered read.
  always_ff @(posedge clk) begin
    q <= LOG_ROM[addr];
  end

endmodule

`default_nettype wire

@@ rtl/core/bce_div.sv @@
// ---------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bce_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [bce_pkg::DVD_BITS-1:0]  dividend,
  input  wire logic [bce_pkg::DSR_BITS-1:0]  divisor,
  output logic      [bce_pkg::DVD_BITS-1:0]  quotient,
  output logic                               done
);
  import bce_pkg::*;

  localparam int CNT_BITS = $clog2(DVD_BITS);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [DSR_BITS-1:0] rem;
  logic [DSR_BITS-1:0] dsr;
  logic [DVD_BITS-1:0] dvd;
  logic [DSR_BITS:0]   rem_sh;
  logic [DSR_BITS:0]   diff;

  // Shift in the next dividend bit and trial subtract.
  assign rem_sh = {rem, dvd[DVD_BITS-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(DVD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      dvd      <= dividend;
      quotient <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_BITS-2:0], 1'b0};
      if (!diff[DSR_BITS]) begin
        rem      <= diff[DSR_BITS-1:0];
        quotient <= {quotient[DVD_BITS-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[DSR_BITS-1:0];
        quotient <= {quotient[DVD_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bce_ctrl.sv @@
// ---------------------------------------------------------------------------
// Controller
// State machine sequencing the loss and gradient steps of one word.
// ---------------------------------------------------------------------------
`default_nettype none

module bce_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bce_pkg::status_t sts,
  output bce_pkg::op_t          op
);
  import bce_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  // Next state and command.
  always_comb begin
    state_next = state;
    op         = OP_NOP;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.kind == KIND_FORWARD) begin
          state_next = ST_LOG_A;
        end else if (sts.grad_enable) begin
          state_next = ST_DIV_QA;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_LOG_A:  begin op = OP_LOG_A;  state_next = ST_LN_A;   end
      ST_LN_A:   begin op = OP_LN_MUL; state_next = ST_SAVE_A; end
      ST_SAVE_A: begin op = OP_SAVE_A; state_next = ST_LOG_B;  end
      ST_LOG_B:  begin op = OP_LOG_B;  state_next = ST_LN_B;   end
      ST_LN_B:   begin op = OP_LN_MUL; state_next = ST_SAVE_B; end
      ST_SAVE_B: begin op = OP_SAVE_B; state_next = ST_MUL_YA; end
      ST_MUL_YA: begin op = OP_MUL_YA; state_next = ST_MUL_YB; end
      ST_MUL_YB: begin op = OP_MUL_YB; state_next = ST_ACCUM;  end
      ST_ACCUM: begin
        op         = OP_ACCUM;
        state_next = sts.last ? ST_DIV_MEAN : ST_IDLE;
      end
      ST_DIV_MEAN: begin op = OP_DIV_MEAN; state_next = ST_WAIT_MEAN; end
      ST_WAIT_MEAN: begin
        if (sts.div_done) begin
          state_next = ST_OUT_LOSS;
        end
      end
      ST_OUT_LOSS: begin
        if (sts.out_free) begin
          op         = OP_OUT_LOSS;
          state_next = ST_IDLE;
        end
      end
      ST_DIV_QA: begin op = OP_DIV_QA; state_next = ST_WAIT_QA; end
      ST_WAIT_QA: begin
        if (sts.div_done) begin
          state_next = ST_SAVE_QA;
        end
      end
      ST_SAVE_QA: begin op = OP_SAVE_QA; state_next = ST_DIV_QB; end
      ST_DIV_QB:  begin op = OP_DIV_QB;  state_next = ST_WAIT_QB; end
      ST_WAIT_QB: begin
        if (sts.div_done) begin
          state_next = ST_SAVE_QB;
        end
      end
      ST_SAVE_QB: begin op = OP_SAVE_QB; state_next = ST_MUL_G; end
      ST_MUL_G:   begin op = OP_MUL_G;   state_next = ST_DIV_G; end
      ST_DIV_G:   begin op = OP_DIV_G;   state_next = ST_WAIT_G; end
      ST_WAIT_G: begin
        if (sts.div_done) begin
          state_next = ST_OUT_GRAD;
        end
      end
      ST_OUT_GRAD: begin
        if (sts.out_free) begin
          op         = OP_OUT_GRAD;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/bce_dp.sv @@
// ---------------------------------------------------------------------------
// Datapath
// Operand registers, shared multiplier, loss state and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bce_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire bce_pkg::op_t                     op,
  input  wire logic                             pass_kind,
  input  wire logic [bce_pkg::P_BITS-1:0]       prediction,
  input  wire logic [bce_pkg::P_BITS-1:0]       target_value,
  input  wire logic signed [bce_pkg::U_BITS-1:0] upstream_grad,
  input  wire logic                             last_item,
  output logic      [bce_pkg::LOG_BITS-1:0]     rom_addr,
  input  wire logic [bce_pkg::L2_BITS-1:0]      rom_q,
  output logic                                  div_start,
  output logic      [bce_pkg::DVD_BITS-1:0]     div_dividend,
  output logic      [bce_pkg::DSR_BITS-1:0]     div_divisor,
  input  wire logic [bce_pkg::DVD_BITS-1:0]     div_quotient,
  output logic                                  item_kind,
  output logic                                  item_last,
  output logic                                  out_free,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  result_kind,
  output logic      [bce_pkg::LOSS_BITS-1:0]    loss_mean,
  output logic signed [bce_pkg::GRAD_BITS-1:0]  grad_value,
  output logic                                  saturated,
  output logic                                  last_result
);
  import bce_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

  // Item registers.
  logic              p_lo;
  logic [14:0]       p;
  logic [15:0]       y;
  logic [U_BITS-1:0] u;
  logic [14:0]       p_clamp;
  logic [15:0]       y_sat;
  logic [14:0]       pc;
  logic [15:0]       yc;

  // Working registers.
  logic [3:0]            shift;
  logic [NLN_BITS-1:0]   a;
  logic [NLN_BITS-1:0]   b;
  logic [PROD_BITS-1:0]  prod;
  logic [35:0]           acc;
  logic [31:0]           qa;
  logic [31:0]           dmag;
  logic                  dneg;
  logic [SUM_BITS-1:0]   loss_sum;
  logic [COUNT_BITS-1:0] item_count;
  logic [COUNT_BITS-1:0] held_count;

  // Combinational helpers.
  logic [14:0]           log_x;
  logic [3:0]            e_pos;
  logic [29:0]           x_norm;
  logic [23:0]           l2;
  logic [MUL_BITS-1:0]   mul_a;
  logic [MUL_BITS-1:0]   mul_b;
  logic [PROD_BITS-1:0]  prod_ln_rnd;
  logic [20:0]           term;
  logic [SUM_BITS:0]     sum_add;
  logic [COUNT_BITS-1:0] n_cur;
  logic [COUNT_BITS-1:0] n_held;
  logic [31:0]           qb;
  logic [31:0]           umag;
  logic                  uneg;
  logic [DVD_BITS-1:0]   mag;
  logic                  gneg;
  logic [GRAD_BITS-1:0]  gval;
  logic                  gsat;

  assign p_lo    = (prediction == '0);
  assign p_clamp = p_lo ? P_MIN :
                   (prediction > {1'b0, P_MAX}) ? P_MAX : prediction[14:0];
  assign y_sat   = (target_value > ONE_Q15) ? ONE_Q15 : target_value;
  assign pc      = 15'(ONE_Q15 - {1'b0, p});
  assign yc      = ONE_Q15 - y;

  // Leading one of the log operand and table index.
  assign log_x = (op == OP_LOG_B) ? pc : p;
  always_comb begin
    e_pos = '0;
    for (int i = 0; i < 15; i++) begin
      if (log_x[i]) begin
        e_pos = 4'(i);
      end
    end
  end
  assign x_norm   = {15'd0, log_x} << (4'd15 - e_pos);
  assign rom_addr = x_norm[14 -: LOG_BITS];
  assign l2       = {shift, 20'd0} - {4'd0, rom_q};

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    priority case (op)
      OP_LN_MUL: begin mul_a = 32'(l2); mul_b = 32'(LN2_Q30); end
      OP_MUL_YA: begin mul_a = 32'(y);  mul_b = 32'(a);       end
      OP_MUL_YB: begin mul_a = 32'(yc); mul_b = 32'(b);       end
      OP_MUL_G:  begin mul_a = dmag;    mul_b = umag;         end
      default: ;
    endcase
  end

  assign prod_ln_rnd = prod + (64'd1 << 33);
  assign term        = 21'((37'(acc) + 37'(prod[34:0]) + 37'd16384) >> 15);
  assign sum_add     = {1'b0, loss_sum} + 41'(term);
  assign n_cur       = (item_count == '0) ? COUNT_BITS'(1) : item_count;
  assign n_held      = (held_count == '0) ? COUNT_BITS'(1) : held_count;
  assign qb          = div_quotient[31:0];
  assign uneg        = u[U_BITS-1];
  assign umag        = uneg ? (32'd0 - u) : u;

  // Divider operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    priority case (op)
      OP_DIV_MEAN: begin
        div_start    = 1'b1;
        div_dividend = 64'(loss_sum) + 64'(n_cur >> 1);
        div_divisor  = DSR_BITS'(n_cur);
      end
      OP_DIV_QA: begin
        div_start    = 1'b1;
        div_dividend = 64'(y) << 16;
        div_divisor  = DSR_BITS'(p);
      end
      OP_DIV_QB: begin
        div_start    = 1'b1;
        div_dividend = 64'(yc) << 16;
        div_divisor  = DSR_BITS'(pc);
      end
      OP_DIV_G: begin
        div_start    = 1'b1;
        div_dividend = prod + (64'(n_held) << 15);
        div_divisor  = {n_held, 16'd0};
      end
      default: ;
    endcase
  end

  // Sign, rounding result and clipping of the gradient.
  assign mag = div_quotient;
  always_comb begin
    gneg = (dneg != uneg) && (prod != '0) && (mag != '0);
    gsat = 1'b0;
    if (gneg) begin
      if (mag > (64'd1 << 39)) begin
        gval = {1'b1, 39'd0};
        gsat = 1'b1;
      end else begin
        gval = 40'(64'd0 - mag);
      end
    end else begin
      if (mag > ((64'd1 << 39) - 64'd1)) begin
        gval = {1'b0, {39{1'b1}}};
        gsat = 1'b1;
      end else begin
        gval = mag[GRAD_BITS-1:0];
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        item_kind <= pass_kind;
        item_last <= last_item;
        p         <= p_clamp;
        y         <= y_sat;
        u         <= upstream_grad;
      end
      OP_LOG_A, OP_LOG_B: shift <= 4'd15 - e_pos;
      OP_LN_MUL: prod <= 64'(mul_a) * 64'(mul_b);
      OP_SAVE_A: a <= prod_ln_rnd[34 +: NLN_BITS];
      OP_SAVE_B: b <= prod_ln_rnd[34 +: NLN_BITS];
      OP_MUL_YA: prod <= 64'(mul_a) * 64'(mul_b);
      OP_MUL_YB: begin
        acc  <= prod[35:0];
        prod <= 64'(mul_a) * 64'(mul_b);
      end
      OP_SAVE_QA: qa <= qb;
      OP_SAVE_QB: begin
        dneg <= qa > qb;
        dmag <= (qa > qb) ? (qa - qb) : (qb - qa);
      end
      OP_MUL_G: prod <= 64'(mul_a) * 64'(mul_b);
      OP_NOP, OP_ACCUM, OP_DIV_MEAN, OP_OUT_LOSS, OP_DIV_QA, OP_DIV_QB,
      OP_DIV_G, OP_OUT_GRAD: ;
      default: ;
    endcase
  end

  // Loss sum, item count and held count.
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_sum   <= '0;
      item_count <= '0;
      held_count <= COUNT_BITS'(1);
    end else if (op == OP_ACCUM) begin
      loss_sum <= sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
      if (item_count != COUNT_MAX) begin
        item_count <= item_count + 1'b1;
      end
    end else if (op == OP_OUT_LOSS) begin
      held_count <= item_count;
      loss_sum   <= '0;
      item_count <= '0;
    end
  end

  // Output register.
  assign out_free = !out_valid || !out_stall;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT_LOSS || op == OP_OUT_GRAD) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT_LOSS) begin
      result_kind <= KIND_FORWARD;
      loss_mean   <= (mag > 64'((1 << LOSS_BITS) - 1)) ? '1 : mag[LOSS_BITS-1:0];
      grad_value  <= '0;
      saturated   <= 1'b0;
      last_result <= 1'b1;
    end else if (op == OP_OUT_GRAD) begin
      result_kind <= KIND_BACKWARD;
      loss_mean   <= '0;
      grad_value  <= gval;
      saturated   <= gsat;
      last_result <= item_last;
    end
  end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ---------------------------------------------------------------------------
// Binary cross-entropy unit testbench
// Drives forward and backward words with random idling on both sides,
// predicts each mean loss and gradient in a scoreboard and checks the
// results in order. The gradient enable register is swept between phases.
// ---------------------------------------------------------------------------
`default_nettype none

// Scoreboard: keeps its own copy of the loss state and the pending results.
class bce_scoreboard;
  typedef struct packed {
    logic        kind;
    logic [20:0] loss;
    logic [39:0] grad;
    logic        sat;
    logic        last;
  } bce_result_t;

  logic [19:0] log_rom [1024];
  bit          grad_on;
  logic [39:0] sum_acc;
  logic [19:0] count_acc;
  logic [19:0] count_held;
  bce_result_t pending [$];
  int          errors;

  function new();
    logic [63:0] v;
    logic [19:0] r;
    for (int i = 0; i < 1024; i++) begin
      v = (64'd1 << 30) + ((64'(i) << 30) / 1024);
      r = '0;
      for (int k = 0; k < 20; k++) begin
        v = (v * v) >> 30;
        r = r << 1;
        if (v >= (64'd2 << 30)) begin
          v = v >> 1;
          r[0] = 1'b1;
        end
      end
      log_rom[i] = r;
    end
    grad_on = 1;
    sum_acc = '0;
    count_acc = '0;
    count_held = 20'd1;
    errors = 0;
  endfunction

  // -ln(x / 2^15) in Q16 through the log2 table.
  function logic [63:0] minus_ln(logic [63:0] x);
    int e;
    logic [63:0] frac, idx, l2;
    e = 14;
    while (e > 0 && x[e] == 1'b0) e--;
    frac = ((x << (15 - e)) & 64'hFFFF) - 64'd32768;
    idx = (frac * 1024) >> 15;
    l2 = (64'(15 - e) << 20) - 64'(log_rom[idx]);
    return (l2 * 64'd744261118 + (64'd1 << 33)) >> 34;
  endfunction

  // Note an accepted word and queue the result it causes, if any.
  function void note_word(bit kind, logic [15:0] pin, logic [15:0] yin,
                          logic [31:0] ubits, bit last);
    logic [63:0] p, y, a, b, term, s, n, mean, qa, qb, dmag, umag, prod, den, mag;
    bit dneg, uneg, neg, sat;
    bce_result_t r;
    p = pin; y = yin;
    if (p < 1) p = 1;
    if (p > 32767) p = 32767;
    if (y > 32768) y = 32768;
    r = '0;
    if (!kind) begin
      a = minus_ln(p);
      b = minus_ln(32768 - p);
      term = (y * a + (32768 - y) * b + (64'd1 << 14)) >> 15;
      s = 64'(sum_acc) + term;
      if (s > 64'hFF_FFFF_FFFF) s = 64'hFF_FFFF_FFFF;
      sum_acc = s[39:0];
      if (count_acc != 20'hFFFFF) count_acc++;
      if (!last) return;
      n = count_acc ? 64'(count_acc) : 1;
      mean = (64'(sum_acc) + n / 2) / n;
      if (mean > 64'h1F_FFFF) mean = 64'h1F_FFFF;
      count_held = count_acc;
      sum_acc = '0;
      count_acc = '0;
      r.loss = mean[20:0];
      r.last = 1;
    end else begin
      if (!grad_on) return;
      qa = (y << 16) / p;
      qb = ((64'd32768 - y) << 16) / (64'd32768 - p);
      dneg = qa > qb;
      dmag = dneg ? qa - qb : qb - qa;
      uneg = ubits[31];
      umag = uneg ? (64'h1_0000_0000 - 64'(ubits)) : 64'(ubits);
      neg = dneg != uneg;
      prod = dmag * umag;
      n = count_held ? 64'(count_held) : 1;
      den = n << 16;
      mag = (prod + den / 2) / den;
      if (prod == 0 || mag == 0) neg = 0;
      sat = 0;
      if (neg) begin
        if (mag > (64'd1 << 39)) begin
          mag = 64'd1 << 39; sat = 1;
        end
        r.grad = 40'(0 - mag);
      end else begin
        if (mag > ((64'd1 << 39) - 1)) begin
          mag = (64'd1 << 39) - 1; sat = 1;
        end
        r.grad = mag[39:0];
      end
      r.kind = 1;
      r.sat = sat;
      r.last = last;
    end
    pending.push_back(r);
  endfunction

  // Compare one accepted result with the oldest expectation.
  function void check_result(bce_result_t got);
    bce_result_t w;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result kind=%0d", $realtime, got.kind);
      errors++;
      return;
    end
    w = pending.pop_front();
    if (got.kind !== w.kind) begin
      $display("%0t: result_kind expected %0d actual %0d", $realtime, w.kind, got.kind);
      errors++;
    end
    if (got.loss !== w.loss) begin
      $display("%0t: loss_mean expected %0d actual %0d", $realtime, w.loss, got.loss);
      errors++;
    end
    if (got.grad !== w.grad) begin
      $display("%0t: grad_value expected %0d actual %0d", $realtime,
               $signed(w.grad), $signed(got.grad));
      errors++;
    end
    if (got.sat !== w.sat) begin
      $display("%0t: saturated expected %0d actual %0d", $realtime, w.sat, got.sat);
      errors++;
    end
    if (got.last !== w.last) begin
      $display("%0t: last_result expected %0d actual %0d", $realtime, w.last, got.last);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bce_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic pass_kind = 0;
  logic [P_BITS-1:0] prediction = '0, target_value = '0;
  logic signed [U_BITS-1:0] upstream_grad = '0;
  logic last_item = 0;
  logic out_valid;
  logic out_stall = 0;
  logic result_kind, saturated, last_result;
  logic [LOSS_BITS-1:0] loss_mean;
  logic signed [GRAD_BITS-1:0] grad_value;

  bce_scoreboard board = new();
  bit calm = 0;    // no idling on either side while set
  int cycles = 0;

  binary_cross_entropy_unit uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Timeout watch.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random stall and checking.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result({result_kind, loss_mean, grad_value, saturated, last_result});
    out_stall <= rst ? 1'b0 : (!calm && $urandom_range(99) < 37);
  end

  // Register write through setup and access cycles.
  task automatic write_grad_enable(bit v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_GRAD_ENABLE; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.grad_on = v;
  endtask

  // Offer one word, holding it until accepted. Valid stays high after the
  // accepting edge and is replaced or dropped in that same time step.
  task automatic send_word(bit kind, logic [15:0] p, logic [15:0] y,
                           logic [31:0] u, bit last);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; pass_kind <= kind; prediction <= p;
    target_value <= y; upstream_grad <= u; last_item <= last;
    do @(posedge clk); while (in_stall);
    board.note_word(kind, p, y, u, last);
  endtask

  // Wait for every pending result, then let the block settle.
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_prob();
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(3));
      2: return 16'($urandom_range(32768, 32764));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [31:0] rand_grad();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(131072)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sent, len;
    repeat (5) @(posedge clk);
    rst <= 0;

    // Directed: backward with the reset held count, then edge predictions.
    send_word(1, 16'd16384, 16'd0, 32'h0001_0000, 0);
    send_word(1, 16'd0, 16'd32768, 32'h7FFF_FFFF, 0);
    send_word(1, 16'hFFFF, 16'd0, 32'h8000_0000, 1);
    send_word(0, 16'd0, 16'd0, 0, 0);
    send_word(0, 16'd32768, 16'd32768, 0, 0);
    send_word(0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send_word(0, 16'd1, 16'd32768, 0, 0);
    send_word(0, 16'd32767, 16'd0, 0, 1);
    send_word(0, 16'd1, 16'd32768, 0, 1);
    send_word(1, 16'd1, 16'd32768, 32'h7FFF_FFFF, 0);
    send_word(1, 16'd32767, 16'd0, 32'h8000_0000, 0);
    send_word(1, 16'd16384, 16'd16384, 32'h1234_5678, 0);
    send_word(1, 16'd100, 16'd200, 32'd0, 1);
    drain();
    write_grad_enable(0);
    send_word(1, 16'd1000, 16'd0, 32'h0001_0000, 0);
    send_word(0, 16'd1000, 16'd5000, 0, 1);
    send_word(1, 16'd1000, 16'd0, 32'h0001_0000, 1);
    drain();
    write_grad_enable(1);

    // Random tensors: a forward pass then its backward pass.
    sent = 0;
    while (sent < 1450) begin
      calm = (sent > 600 && sent < 800);
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++)
        send_word(0, rand_prob(), rand_prob(), $urandom, i == len - 1);
      for (int i = 0; i < len; i++)
        send_word(1, rand_prob(), rand_prob(), rand_grad(), i == len - 1);
      if ($urandom_range(7) == 0)
        send_word(1'($urandom), rand_prob(), rand_prob(), rand_grad(), 1'($urandom));
      sent += 2 * len;
      if ($urandom_range(19) == 0) begin
        drain();
        write_grad_enable(1'($urandom));
      end
    end
    drain();
    write_grad_enable(1);
    send_word(1, rand_prob(), rand_prob(), rand_grad(), 1);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire
